@@ hdl/vws_pkg.sv @@
// ----------------------------------------------------------------------------
// vws_pkg
// Shared widths, register indexes, sequencer states and axis scaling for the
// vibration window statistics block.
// ----------------------------------------------------------------------------
package vws_pkg;

    localparam int MUL_W   = 27;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int RAD_W   = 52;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int NUM_W   = 63;
    localparam int DEN_W   = 13;
    localparam int AXIS_W  = 25;
    localparam int BASE_W  = 42;
    localparam int BASE_FRAC = 16;

    localparam logic [1:0] CFG_ALPHA    = 2'd0;
    localparam logic [1:0] CFG_FULL_RES = 2'd1;
    localparam logic [1:0] CFG_RANGE    = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [20:0] {
        ST_IDLE   = 21'h000001,
        ST_DIFF   = 21'h000002,
        ST_MLO    = 21'h000004,
        ST_MHI    = 21'h000008,
        ST_UPD    = 21'h000010,
        ST_DELTA  = 21'h000020,
        ST_SQD    = 21'h000040,
        ST_ACC    = 21'h000080,
        ST_MAGGO  = 21'h000100,
        ST_MAGW   = 21'h000200,
        ST_DYNGO  = 21'h000400,
        ST_DYNW   = 21'h000800,
        ST_DSQ    = 21'h001000,
        ST_WIN    = 21'h002000,
        ST_DIV1GO = 21'h004000,
        ST_DIV1W  = 21'h008000,
        ST_DIV2GO = 21'h010000,
        ST_DIV2W  = 21'h020000,
        ST_RTGO   = 21'h040000,
        ST_RTW    = 21'h080000,
        ST_OUT    = 21'h100000
    } t_state;

    function automatic logic signed [AXIS_W-1:0] scale_axis(
        input logic signed [15:0] raw,
        input logic               full_res,
        input logic [1:0]         rng
    );
        logic signed [AXIS_W-1:0] v;
        v = (AXIS_W'(raw) <<< 5) + (AXIS_W'(raw) <<< 2) + (AXIS_W'(raw) <<< 1)
            + AXIS_W'(raw);
        if (!full_res) begin
            v = v <<< rng;
        end
        return v;
    endfunction

endpackage

@@ hdl/vws_mul.sv @@
// ----------------------------------------------------------------------------
// vws_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module vws_mul import vws_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ hdl/vws_sqrt.sv @@
// ----------------------------------------------------------------------------
// vws_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vws_sqrt import vws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W+2:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+2:0] w_rem2;
    logic [ROOT_W+2:0] w_trial;

    assign w_rem2  = {r_rem[ROOT_W:0], r_rad[RAD_W-1:RAD_W-2]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CNT_W'(ROOT_W - 1);
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rad <= r_rad << 2;
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hdl/vws_div.sv @@
// ----------------------------------------------------------------------------
// vws_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vws_div import vws_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_rem2;

    assign w_rem2 = {r_rem, r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(NUM_W - 1);
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_rem2 >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(w_rem2 - {1'b0, r_den});
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ hdl/vibration_window_stats_unit.sv @@
// ----------------------------------------------------------------------------
// vibration_window_stats_unit
// Baseline-tracking vibration monitor with windowed mean, rms and peak.
// ----------------------------------------------------------------------------
// sample request: busy after acceptance while each axis runs on the shared
//   multiplier (no baseline update for the first sample), then for two
//   square roots and the window update; no result
// report request: with samples in the window, busy for two divides, one
//   square root and the output step (output step alone when empty), plus
//   any wait for the output register; one request at a time. Synchronous
//   active-low reset loads register defaults, clears control and window state
module vibration_window_stats_unit import vws_pkg::*; #(
    parameter int WINDOW_CAPACITY     = 4096,
    parameter int ALPHA_FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [16:0]              i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_operation,
    input  logic signed [15:0]       i_raw_x,
    input  logic signed [15:0]       i_raw_y,
    input  logic signed [15:0]       i_raw_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [AXIS_W-1:0] o_last_x,
    output logic signed [AXIS_W-1:0] o_last_y,
    output logic signed [AXIS_W-1:0] o_last_z,
    output logic [AXIS_W-1:0]        o_magnitude,
    output logic [25:0]              o_mean_dynamic,
    output logic [25:0]              o_rms_dynamic,
    output logic [25:0]              o_peak_dynamic,
    output logic [12:0]              o_window_samples,
    output logic                     o_window_saturated
);

    t_state r_state;

    logic [16:0] r_alpha;
    logic        r_full_res;
    logic [1:0]  r_range;

    logic signed [AXIS_W-1:0] r_x [3];
    logic signed [BASE_W-1:0] r_b [3];
    logic                     r_bvalid;
    logic [1:0]               r_ax;
    logic signed [BASE_W:0]   r_diff;
    logic [38:0]              r_plo;
    logic signed [MUL_W-1:0]  r_d;
    logic [RAD_W-1:0]         r_msq;
    logic [RAD_W-1:0]         r_dsq;
    logic [AXIS_W-1:0]        r_mag;
    logic [ROOT_W-1:0]        r_dyn;

    logic [12:0] r_count;
    logic [38:0] r_sum;
    logic [62:0] r_sq;
    logic [25:0] r_peak;
    logic        r_ovf;
    logic [25:0] r_mean;
    logic [25:0] r_rms;
    logic [RAD_W-1:0] r_q2;

    logic                     r_ovalid;
    logic signed [AXIS_W-1:0] r_o_x;
    logic signed [AXIS_W-1:0] r_o_y;
    logic signed [AXIS_W-1:0] r_o_z;
    logic [AXIS_W-1:0]        r_o_mag;
    logic [25:0]              r_o_mean;
    logic [25:0]              r_o_rms;
    logic [25:0]              r_o_peak;
    logic [12:0]              r_o_cnt;
    logic                     r_o_sat;

    logic                     w_accept;
    logic [16:0]              w_alpha;
    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_p;
    logic signed [60:0]       w_prod;
    logic signed [60:0]       w_step;
    logic                     w_sq_start;
    logic [RAD_W-1:0]         w_rad;
    logic                     w_sq_done;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_dv_start;
    logic [NUM_W-1:0]         w_num;
    logic                     w_dv_done;
    logic [NUM_W-1:0]         w_quot;
    logic                     w_out_free;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;

    assign w_alpha = (r_alpha > 17'(1 << ALPHA_FRACTION_BITS))
                   ? 17'(1 << ALPHA_FRACTION_BITS) : r_alpha;

    assign w_prod = (61'(w_p) <<< 22) + 61'(r_plo);
    assign w_step = w_prod >>> ALPHA_FRACTION_BITS;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_MLO: begin
                w_ma = MUL_W'({1'b0, r_diff[21:0]});
                w_mb = MUL_W'({1'b0, w_alpha});
            end
            ST_MHI: begin
                w_ma = MUL_W'($signed(r_diff[BASE_W:22]));
                w_mb = MUL_W'({1'b0, w_alpha});
            end
            ST_DELTA: begin
                w_ma = MUL_W'(r_x[r_ax]);
                w_mb = MUL_W'(r_x[r_ax]);
            end
            ST_SQD: begin
                w_ma = r_d;
                w_mb = r_d;
            end
            ST_DSQ: begin
                w_ma = MUL_W'({1'b0, r_dyn});
                w_mb = MUL_W'({1'b0, r_dyn});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        w_rad = r_msq;
        case (r_state)
            ST_DYNGO: w_rad = r_dsq;
            ST_RTGO:  w_rad = r_q2;
            default:  w_rad = r_msq;
        endcase
    end

    assign w_sq_start = (r_state == ST_MAGGO) || (r_state == ST_DYNGO)
                     || (r_state == ST_RTGO);
    assign w_dv_start = (r_state == ST_DIV1GO) || (r_state == ST_DIV2GO);
    assign w_num      = (r_state == ST_DIV2GO) ? r_sq : NUM_W'(r_sum);

    vws_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    vws_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    vws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_num),
        .i_den   (r_count),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= 17'd655;
            r_full_res <= 1'b0;
            r_range    <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:    r_alpha    <= i_cfg_data;
                CFG_FULL_RES: r_full_res <= i_cfg_data[0];
                CFG_RANGE:    r_range    <= i_cfg_data[1:0];
                default:      r_alpha    <= r_alpha;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_bvalid <= 1'b0;
            r_count  <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_peak   <= '0;
            r_ovf    <= 1'b0;
            r_mag    <= '0;
            r_ovalid <= 1'b0;
            r_ax     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_x[i] <= '0;
                r_b[i] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_operation == OP_SAMPLE) begin
                            r_x[0] <= scale_axis(i_raw_x, r_full_res, r_range);
                            r_x[1] <= scale_axis(i_raw_y, r_full_res, r_range);
                            r_x[2] <= scale_axis(i_raw_z, r_full_res, r_range);
                            r_ax   <= '0;
                            r_msq  <= '0;
                            r_dsq  <= '0;
                            r_state <= ST_DIFF;
                        end else begin
                            r_mean <= '0;
                            r_rms  <= '0;
                            r_state <= (r_count == '0) ? ST_OUT : ST_DIV1GO;
                        end
                    end
                end
                ST_DIFF: begin
                    r_diff <= {{2{r_x[r_ax][AXIS_W-1]}}, r_x[r_ax], 16'b0}
                            - {r_b[r_ax][BASE_W-1], r_b[r_ax]};
                    if (!r_bvalid) begin
                        r_b[r_ax] <= {{1{r_x[r_ax][AXIS_W-1]}}, r_x[r_ax], 16'b0};
                        r_state   <= ST_DELTA;
                    end else begin
                        r_state <= ST_MLO;
                    end
                end
                ST_MLO: r_state <= ST_MHI;
                ST_MHI: begin
                    r_plo   <= w_p[38:0];
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_b[r_ax] <= r_b[r_ax] + w_step[BASE_W-1:0];
                    r_state   <= ST_DELTA;
                end
                ST_DELTA: begin
                    r_d <= MUL_W'(r_x[r_ax]) - MUL_W'(r_b[r_ax] >>> BASE_FRAC);
                    r_state <= ST_SQD;
                end
                ST_SQD: begin
                    r_msq   <= r_msq + w_p[RAD_W-1:0];
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_dsq <= r_dsq + w_p[RAD_W-1:0];
                    if (r_ax == 2'd2) begin
                        r_state <= ST_MAGGO;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= ST_DIFF;
                    end
                end
                ST_MAGGO: r_state <= ST_MAGW;
                ST_MAGW: begin
                    if (w_sq_done) begin
                        r_mag   <= w_root[AXIS_W-1:0];
                        r_state <= ST_DYNGO;
                    end
                end
                ST_DYNGO: r_state <= ST_DYNW;
                ST_DYNW: begin
                    if (w_sq_done) begin
                        r_dyn   <= w_root;
                        r_state <= ST_DSQ;
                    end
                end
                ST_DSQ: r_state <= ST_WIN;
                ST_WIN: begin
                    r_bvalid <= 1'b1;
                    if (r_count >= 13'(WINDOW_CAPACITY)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 13'd1;
                        r_sum   <= r_sum + 39'(r_dyn);
                        r_sq    <= r_sq + 63'(w_p[RAD_W-1:0]);
                        if (r_dyn > r_peak) begin
                            r_peak <= r_dyn;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                ST_DIV1GO: r_state <= ST_DIV1W;
                ST_DIV1W: begin
                    if (w_dv_done) begin
                        r_mean  <= w_quot[25:0];
                        r_state <= ST_DIV2GO;
                    end
                end
                ST_DIV2GO: r_state <= ST_DIV2W;
                ST_DIV2W: begin
                    if (w_dv_done) begin
                        r_q2    <= w_quot[RAD_W-1:0];
                        r_state <= ST_RTGO;
                    end
                end
                ST_RTGO: r_state <= ST_RTW;
                ST_RTW: begin
                    if (w_sq_done) begin
                        r_rms   <= w_root;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_count  <= '0;
                        r_sum    <= '0;
                        r_sq     <= '0;
                        r_peak   <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_o_x    <= r_x[0];
            r_o_y    <= r_x[1];
            r_o_z    <= r_x[2];
            r_o_mag  <= r_mag;
            r_o_mean <= r_mean;
            r_o_rms  <= r_rms;
            r_o_peak <= r_peak;
            r_o_cnt  <= r_count;
            r_o_sat  <= r_ovf;
        end
    end

    assign o_valid            = r_ovalid;
    assign o_last_x           = r_o_x;
    assign o_last_y           = r_o_y;
    assign o_last_z           = r_o_z;
    assign o_magnitude        = r_o_mag;
    assign o_mean_dynamic     = r_o_mean;
    assign o_rms_dynamic      = r_o_rms;
    assign o_peak_dynamic     = r_o_peak;
    assign o_window_samples   = r_o_cnt;
    assign o_window_saturated = r_o_sat;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 13'(WINDOW_CAPACITY))
        else $error("window count above capacity");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == 13'(WINDOW_CAPACITY))
        else $error("saturation flag without full window");

    a_stats_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_o_mean <= r_o_peak) && (r_o_rms <= r_o_peak))
        else $error("mean or rms above peak");
`endif

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vibration_window_stats_unit. A driver runs from a
// request queue; every accepted request steps a local model of the baseline
// and the window statistics, and register writes update its register file.
// A monitor compares each whole report with the oldest expected
// window report. Covers register sweeps, a full window that saturates, empty
// windows, output back-pressure and random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import vws_pkg::*;

    localparam int  CAPACITY   = 4096;
    localparam int  LIMIT      = 3000000;
    localparam int  DRAIN      = 250;

    typedef struct {
        logic               op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } accel_req_t;

    typedef struct packed {
        logic signed [24:0] lx;
        logic signed [24:0] ly;
        logic signed [24:0] lz;
        logic [24:0]        mag;
        logic [25:0]        mean;
        logic [25:0]        rms;
        logic [25:0]        peak;
        logic [12:0]        cnt;
        logic               sat;
    } window_report_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [16:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic signed [15:0] i_raw_x;
    logic signed [15:0] i_raw_y;
    logic signed [15:0] i_raw_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [24:0] o_last_x;
    logic signed [24:0] o_last_y;
    logic signed [24:0] o_last_z;
    logic [24:0]        o_magnitude;
    logic [25:0]        o_mean_dynamic;
    logic [25:0]        o_rms_dynamic;
    logic [25:0]        o_peak_dynamic;
    logic [12:0]        o_window_samples;
    logic               o_window_saturated;

    vibration_window_stats_unit uut (.*);

    accel_req_t     req_q[$];
    window_report_t report_q[$];
    int             mismatches;
    int             cycles;
    int             send_gap;
    int             recv_stall;
    int             hold_cnt;
    bit             quiet;
    logic           sent;

    // model registers and state
    int unsigned     m_alpha;
    bit              m_full_res;
    bit [1:0]        m_range;
    longint          m_base[3];
    bit              m_base_ok;
    longint          m_last[3];
    longint unsigned m_mag;
    longint unsigned m_count;
    longint unsigned m_sum;
    longint unsigned m_sqsum;
    longint unsigned m_peak;
    bit              m_ovf;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic track_request(input accel_req_t r);
        longint          a;
        longint          v;
        longint          d;
        longint unsigned msq;
        longint unsigned dsq;
        longint unsigned dyn;
        logic signed [15:0] raw[3];
        window_report_t  rep;
        if (r.op == OP_SAMPLE) begin
            raw[0] = r.x;
            raw[1] = r.y;
            raw[2] = r.z;
            a = (m_alpha > 65536) ? 65536 : m_alpha;
            msq = 0;
            dsq = 0;
            for (int i = 0; i < 3; i++) begin
                v = longint'(raw[i]) * 39;
                if (!m_full_res) v = v * (64'sd1 << m_range);
                if (!m_base_ok) m_base[i] = v * 65536;
                else m_base[i] = m_base[i] + (((v * 65536 - m_base[i]) * a) >>> 16);
                d = v - (m_base[i] >>> 16);
                m_last[i] = v;
                msq = msq + longint'(v * v);
                dsq = dsq + longint'(d * d);
            end
            m_base_ok = 1;
            m_mag = int_sqrt(msq);
            dyn = int_sqrt(dsq);
            if (m_count >= CAPACITY) begin
                m_ovf = 1;
            end else begin
                m_count++;
                m_sum = m_sum + dyn;
                m_sqsum = m_sqsum + dyn * dyn;
                if (dyn > m_peak) m_peak = dyn;
            end
        end else begin
            rep.lx = m_last[0][24:0];
            rep.ly = m_last[1][24:0];
            rep.lz = m_last[2][24:0];
            rep.mag = m_mag[24:0];
            rep.mean = (m_count > 0) ? 26'(m_sum / m_count) : '0;
            rep.rms = (m_count > 0) ? 26'(int_sqrt(m_sqsum / m_count)) : '0;
            rep.peak = (m_count > 0) ? m_peak[25:0] : '0;
            rep.cnt = m_count[12:0];
            rep.sat = m_ovf;
            report_q.push_back(rep);
            m_count = 0;
            m_sum = 0;
            m_sqsum = 0;
            m_peak = 0;
            m_ovf = 0;
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // request driver
    always @(posedge i_clk) begin
        sent <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            track_request('{i_operation, i_raw_x, i_raw_y, i_raw_z});
        end
    end

    always @(negedge i_clk) begin
        accel_req_t r;
        logic       nv;
        if (i_rst_n && (!i_valid || sent)) begin
            nv = 0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                nv = 1;
                i_operation <= r.op;
                i_raw_x <= r.x;
                i_raw_y <= r.y;
                i_raw_z <= r.z;
                if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
            end
            i_valid <= nv;
        end
    end

    // report monitor
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 0;
        if (hold_cnt > 0) begin
            hold_cnt--;
        end else if (recv_stall > 0) begin
            recv_stall--;
        end else begin
            rdy = 1;
            if (!quiet && $urandom_range(0, 5) == 0) recv_stall = $urandom_range(1, 16);
        end
        i_ready <= rdy;
    end

    always @(posedge i_clk) begin
        window_report_t e;
        window_report_t g;
        if (i_rst_n && o_valid && i_ready) begin
            g = '{o_last_x, o_last_y, o_last_z, o_magnitude, o_mean_dynamic,
                  o_rms_dynamic, o_peak_dynamic, o_window_samples, o_window_saturated};
            if (report_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected report %p", g);
            end else begin
                e = report_q.pop_front();
                if (g != e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("report mismatch exp %p got %p", e, g);
                end
            end
        end
    end

    function automatic logic signed [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3, 4, 5: return 16'($urandom);
            default: return 16'($urandom_range(0, 600)) - 16'sd300;
        endcase
    endfunction

    task automatic add_sample(input logic signed [15:0] x, y, z);
        req_q.push_back('{OP_SAMPLE, x, y, z});
    endtask

    task automatic add_report();
        req_q.push_back('{OP_REPORT, 16'($urandom), 16'($urandom), 16'($urandom)});
    endtask

    task automatic add_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) add_report();
            else add_sample(pick_raw(), pick_raw(), pick_raw());
        end
        add_report();
    endtask

    task automatic settle();
        while (req_q.size() > 0 || i_valid || report_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ALPHA:    m_alpha = data;
            CFG_FULL_RES: m_full_res = data[0];
            CFG_RANGE:    m_range = data[1:0];
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic set_config(input logic [16:0] a, input logic fr, input logic [1:0] rg);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_FULL_RES, {16'd0, fr});
        write_reg(CFG_RANGE, {15'd0, rg});
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 0;
        i_ready = 0;
        i_operation = OP_SAMPLE;
        i_raw_x = '0;
        i_raw_y = '0;
        i_raw_z = '0;
        sent = 0;
        cycles = 0;
        mismatches = 0;
        send_gap = 0;
        recv_stall = 0;
        hold_cnt = 0;
        quiet = 0;
        m_alpha = 655;
        m_full_res = 0;
        m_range = 0;
        m_base_ok = 0;
        m_mag = 0;
        m_count = 0;
        m_sum = 0;
        m_sqsum = 0;
        m_peak = 0;
        m_ovf = 0;
        for (int i = 0; i < 3; i++) begin
            m_base[i] = 0;
            m_last[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // empty window, extremes, signs, reset defaults
        add_report();
        add_sample(16'sd32767, -16'sd32768, 16'sd0);
        add_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        add_sample(16'sd32767, 16'sd32767, 16'sd32767);
        add_report();
        add_sample(16'sd0, 16'sd0, 16'sd0);
        add_sample(-16'sd1, 16'sd1, -16'sd1);
        add_sample(16'sd1000, -16'sd2000, 16'sd256);
        add_report();
        add_report();
        settle();

        // range ignored under full resolution, zero alpha
        set_config(17'd0, 1'b1, 2'd3);
        add_sample(-16'sd32768, 16'sd32767, 16'sd5);
        add_sample(16'sd100, 16'sd200, -16'sd300);
        add_report();
        settle();

        // widest scale, unit alpha, alpha above one
        set_config(17'd65536, 1'b0, 2'd3);
        add_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        add_sample(16'sd32767, 16'sd32767, 16'sd32767);
        add_report();
        settle();
        write_reg(CFG_ALPHA, 17'h1FFFF);
        add_sample(16'sd12345, -16'sd54, 16'sd32767);
        add_sample(-16'sd32768, 16'sd0, 16'sd7);
        add_report();
        settle();

        // saturate the window, then an empty one
        set_config(17'd4000, 1'b0, 2'd1);
        for (int k = 0; k < CAPACITY + 5; k++) add_sample(pick_raw(), pick_raw(), pick_raw());
        add_report();
        add_report();
        settle();

        // long output hold while input keeps arriving
        set_config(17'd655, 1'b0, 2'd2);
        hold_cnt = 800;
        add_report();
        add_random(40);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_config(17'd1, 1'b0, 2'd0);
                1: set_config(17'd65535, 1'b1, 2'd1);
                2: set_config(17'($urandom_range(0, 131071)), 1'b0, 2'd2);
                3: set_config(17'($urandom_range(0, 65536)), 1'b1, 2'd0);
                4: set_config(17'd32768, 1'b0, 2'd3);
                default: begin
                    set_config(17'($urandom_range(0, 70000)), 1'($urandom), 2'($urandom));
                    quiet = 1;
                end
            endcase
            add_random(90);
            settle();
        end

        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
